>>> hw/rtl/ctlcr_pkg.sv
package ctlcr_pkg;

  localparam int LINE_TAG_BITS = 27;
  localparam int DM_TAG_BITS   = 20;
  localparam int SA_TAG_BITS   = 23;
  localparam int DM_INDEX_BITS = 7;
  localparam int SA_SET_BITS   = 4;
  localparam int OFFSET_BITS   = 5;
  localparam int SLOT_OUT_BITS = 7;

  localparam int DEF_NUM_SLOTS  = 128;
  localparam int DEF_NUM_SETS   = 16;
  localparam int DEF_COUNT_BITS = 16;

  localparam logic [1:0] MODE_FULL   = 2'd0;
  localparam logic [1:0] MODE_DIRECT = 2'd1;

  localparam logic [LINE_TAG_BITS-1:0] MASK_FULL = '1;
  localparam logic [LINE_TAG_BITS-1:0] MASK_DIRECT =
    {{DM_TAG_BITS{1'b1}}, {(LINE_TAG_BITS-DM_TAG_BITS){1'b0}}};
  localparam logic [LINE_TAG_BITS-1:0] MASK_SET =
    {{SA_TAG_BITS{1'b1}}, {(LINE_TAG_BITS-SA_TAG_BITS){1'b0}}};

endpackage

>>> hw/rtl/ctlcr_cell.sv
module ctlcr_cell
  import ctlcr_pkg::*;
#(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     shift_en,
  input  logic                     d_valid,
  input  logic [LINE_TAG_BITS-1:0] d_tag,
  input  logic [COUNT_BITS-1:0]    d_count,
  output logic                     q_valid,
  output logic [LINE_TAG_BITS-1:0] q_tag,
  output logic [COUNT_BITS-1:0]    q_count
);

  logic                     valid_r;
  logic [LINE_TAG_BITS-1:0] tag_r;
  logic [COUNT_BITS-1:0]    count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      count_r <= '0;
    end else if (shift_en) begin
      valid_r <= d_valid;
      count_r <= d_count;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      tag_r <= d_tag;
    end
  end

  assign q_valid = valid_r;
  assign q_tag   = tag_r;
  assign q_count = count_r;

endmodule

>>> hw/rtl/ctlcr_ring.sv
module ctlcr_ring
  import ctlcr_pkg::*;
#(
  parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     shift_en,
  input  logic                     fb_valid,
  input  logic [LINE_TAG_BITS-1:0] fb_tag,
  input  logic [COUNT_BITS-1:0]    fb_count,
  output logic                     head_valid,
  output logic [LINE_TAG_BITS-1:0] head_tag,
  output logic [COUNT_BITS-1:0]    head_count
);

  logic                     v_w [NUM_SLOTS];
  logic [LINE_TAG_BITS-1:0] t_w [NUM_SLOTS];
  logic [COUNT_BITS-1:0]    c_w [NUM_SLOTS];

  // cell i takes from cell i+1, the last cell takes the head's feedback
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    if (i == NUM_SLOTS - 1) begin : g_last
      ctlcr_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
        .clk(clk), .rst_n(rst_n), .shift_en(shift_en),
        .d_valid(fb_valid), .d_tag(fb_tag), .d_count(fb_count),
        .q_valid(v_w[i]), .q_tag(t_w[i]), .q_count(c_w[i])
      );
    end else begin : g_mid
      ctlcr_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
        .clk(clk), .rst_n(rst_n), .shift_en(shift_en),
        .d_valid(v_w[i+1]), .d_tag(t_w[i+1]), .d_count(c_w[i+1]),
        .q_valid(v_w[i]), .q_tag(t_w[i]), .q_count(c_w[i])
      );
    end
  end

  assign head_valid = v_w[0];
  assign head_tag   = t_w[0];
  assign head_count = c_w[0];

endmodule

>>> hw/rtl/cache_tag_lookup_count_replace_unit.sv
// Tag lookup with use-count replacement over NUM_SLOTS slots held in a ring of
// cells that rotates by one slot per cycle while scanning or writing, past a
// single compare point. Each accepted item is captured in the idle state, then
// passes a setup state that reduces the index and set number (no reduction is
// needed when NUM_SLOTS and NUM_SETS cover the raw fields, as at the defaults),
// one full rotation to search for a hit, a free slot and the least-used
// candidate, a second rotation to update the chosen slot, and a done state that
// loads the result. One item is worked at a time; a result waits in the output
// register while the next item is taken, and that item stalls at its end until
// the result is taken.
module cache_tag_lookup_count_replace_unit
  import ctlcr_pkg::*;
#(
  parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
  parameter int NUM_SETS   = DEF_NUM_SETS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [SLOT_OUT_BITS-1:0] out_slot,
  output logic        out_evicted,
  output logic [31:0] out_hit_total
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int SW = $clog2(NUM_SETS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]               state_r, state_nxt;
  logic [1:0]               mode_r;
  logic [LINE_TAG_BITS-1:0] line_r;
  logic [LINE_TAG_BITS-1:0] mask_r;
  logic [DM_INDEX_BITS-1:0] dm_r;
  logic [SA_SET_BITS-1:0]   set_r;
  logic [IW-1:0]            pos_r;
  logic [SW-1:0]            pos_set_r;
  logic                     hit_f_r, free_f_r, have_min_r;
  logic [IW-1:0]            hit_slot_r, free_slot_r, min_slot_r;
  logic [COUNT_BITS-1:0]    min_cnt_r;
  logic [31:0]              hits_r;

  logic                     head_valid;
  logic [LINE_TAG_BITS-1:0] head_tag;
  logic [COUNT_BITS-1:0]    head_count;
  logic                     fb_valid;
  logic [LINE_TAG_BITS-1:0] fb_tag;
  logic [COUNT_BITS-1:0]    fb_count;
  logic                     shift_en, pos_last, cand, match, wr_here;
  logic                     dm_big, set_big;
  logic [IW-1:0]            target;
  logic                     out_load;

  assign in_ready = (state_r == ST_IDLE);
  assign shift_en = (state_r == ST_SCAN) || (state_r == ST_WRITE);
  assign pos_last = (32'(pos_r) == NUM_SLOTS - 1);
  assign dm_big   = (32'(dm_r) >= NUM_SLOTS);
  assign set_big  = (32'(set_r) >= NUM_SETS);

  always_comb begin
    case (mode_r)
      MODE_FULL:   cand = 1'b1;
      MODE_DIRECT: cand = (32'(dm_r) == 32'(pos_r));
      default:     cand = (32'(set_r) == 32'(pos_set_r));
    endcase
  end

  assign match  = head_valid && (((head_tag ^ line_r) & mask_r) == '0);
  assign target = hit_f_r ? hit_slot_r : (free_f_r ? free_slot_r : min_slot_r);
  assign wr_here = (state_r == ST_WRITE) && (pos_r == target);

  // head slot passes back into the tail of the ring, rewritten when it is the chosen slot
  always_comb begin
    fb_valid = head_valid;
    fb_tag   = head_tag;
    fb_count = head_count;
    if (wr_here) begin
      if (!hit_f_r) begin
        fb_valid = 1'b1;
        fb_tag   = line_r;
      end
      if (head_count != '1) begin
        fb_count = head_count + 1'b1;
      end
    end
  end

  ctlcr_ring #(.NUM_SLOTS(NUM_SLOTS), .COUNT_BITS(COUNT_BITS)) u_ring (
    .clk(clk), .rst_n(rst_n), .shift_en(shift_en),
    .fb_valid(fb_valid), .fb_tag(fb_tag), .fb_count(fb_count),
    .head_valid(head_valid), .head_tag(head_tag), .head_count(head_count)
  );

  assign out_load = (state_r == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_PREP;
      ST_PREP:  if (!dm_big && !set_big) state_nxt = ST_SCAN;
      ST_SCAN:  if (pos_last) state_nxt = ST_WRITE;
      ST_WRITE: if (pos_last) state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= MODE_FULL;
      pos_r     <= '0;
      pos_set_r <= '0;
      hits_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) mode_r <= cfg_wdata;
      if (shift_en) begin
        pos_r     <= pos_last ? '0 : pos_r + 1'b1;
        pos_set_r <= (pos_last || 32'(pos_set_r) == NUM_SETS - 1) ? '0 : pos_set_r + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        if (hit_f_r && hits_r != '1) hits_r <= hits_r + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        line_r     <= in_addr[31:OFFSET_BITS];
        dm_r       <= in_addr[OFFSET_BITS +: DM_INDEX_BITS];
        set_r      <= in_addr[OFFSET_BITS +: SA_SET_BITS];
        hit_f_r    <= 1'b0;
        free_f_r   <= 1'b0;
        have_min_r <= 1'b0;
        case (mode_r)
          MODE_FULL:   mask_r <= MASK_FULL;
          MODE_DIRECT: mask_r <= MASK_DIRECT;
          default:     mask_r <= MASK_SET;
        endcase
      end
      ST_PREP: begin
        // subtracts NUM_SLOTS and NUM_SETS until the index and set number are in range
        if (dm_big) dm_r <= dm_r - DM_INDEX_BITS'(NUM_SLOTS);
        if (set_big) set_r <= set_r - SA_SET_BITS'(NUM_SETS);
      end
      ST_SCAN: begin
        if (cand && !hit_f_r) begin
          if (match) begin
            hit_f_r    <= 1'b1;
            hit_slot_r <= pos_r;
          end
          if (!head_valid && !free_f_r) begin
            free_f_r    <= 1'b1;
            free_slot_r <= pos_r;
          end
          if (head_valid && (!have_min_r || head_count < min_cnt_r)) begin
            have_min_r <= 1'b1;
            min_slot_r <= pos_r;
            min_cnt_r  <= head_count;
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_hit     <= hit_f_r;
      out_slot    <= SLOT_OUT_BITS'(target);
      out_evicted <= !hit_f_r && !free_f_r;
      out_hit_total <= (hit_f_r && hits_r != '1) ? hits_r + 1'b1 : hits_r;
    end
  end

endmodule

>>> hw/rtl/ctlcr_checker.sv
module ctlcr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic        out_evicted,
  input logic [31:0] out_hit_total
);

  // one item at a time: taking an item closes the input
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after an item was taken");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted)
    else $error("hit reported with eviction");

  // result never appears while the block is still idle from the start
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_ready && !$past(out_valid) |=> !out_valid || $past(!in_ready))
    else $error("result without an item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit_total))
    else $error("stalled result changed");

endmodule

bind cache_tag_lookup_count_replace_unit ctlcr_checker u_ctlcr_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
  .out_evicted(out_evicted), .out_hit_total(out_hit_total)
);

>>> dv/tb_top.sv
module tb_top
  import ctlcr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = DEF_NUM_SLOTS;
  localparam int NSET = DEF_NUM_SETS;
  localparam logic [1:0] MODE_SET = 2'd2;
  // spare encoding, decodes as set associative
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int PHASE_ITEMS = 125;
  localparam int NUM_PHASES = 6;
  localparam int NUM_ROWS = 19;

  typedef struct packed {
    logic                     hit;
    logic [SLOT_OUT_BITS-1:0] slot;
    logic                     evicted;
    logic [31:0]              total;
  } lookup_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] addr;
    bit          typed;
    lookup_t     want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_addr;
  logic        out_valid;
  logic        out_ready;
  logic        out_hit;
  logic [SLOT_OUT_BITS-1:0] out_slot;
  logic        out_evicted;
  logic [31:0] out_hit_total;

  // predictor state
  logic                     tag_valid [NSLOT];
  logic [LINE_TAG_BITS-1:0] tag_line [NSLOT];
  logic [DEF_COUNT_BITS-1:0] use_cnt [NSLOT];
  logic [31:0]              hits_so_far;
  logic [1:0]               cur_mode;

  lookup_t expected_lookups[$];
  int      mismatches = 0;
  int      accepted = 0;
  int      returned = 0;
  int      cycles = 0;
  bit      hold_results = 1'b0;
  row_t    rows [NUM_ROWS];

  cache_tag_lookup_count_replace_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_addr(in_addr),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .out_slot(out_slot), .out_evicted(out_evicted), .out_hit_total(out_hit_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cache_tag_lookup_count_replace_unit verification failed");
      $finish;
    end
  end

  task automatic predict_lookup(input logic [31:0] a, output lookup_t r);
    logic [LINE_TAG_BITS-1:0] line;
    bit set_mode;
    int set_no;
    int sh;
    bit found_free;
    bit have_min;
    int min_slot;
    int sl;
    bit h;
    bit ev;
    line = a[31:OFFSET_BITS];
    h = 1'b0;
    ev = 1'b0;
    sl = 0;
    if (cur_mode == MODE_DIRECT) begin
      sl = line[DM_INDEX_BITS-1:0] % NSLOT;
      if (tag_valid[sl] && (tag_line[sl] >> (LINE_TAG_BITS - DM_TAG_BITS)) ==
          (line >> (LINE_TAG_BITS - DM_TAG_BITS)))
        h = 1'b1;
      else
        ev = tag_valid[sl];
    end else begin
      set_mode = (cur_mode != MODE_FULL);
      set_no = line[SA_SET_BITS-1:0] % NSET;
      sh = set_mode ? (LINE_TAG_BITS - SA_TAG_BITS) : 0;
      found_free = 1'b0;
      have_min = 1'b0;
      min_slot = 0;
      for (int s = 0; s < NSLOT; s++) begin
        if ((!set_mode || s % NSET == set_no) && tag_valid[s] &&
            (tag_line[s] >> sh) == (line >> sh)) begin
          h = 1'b1;
          sl = s;
          break;
        end
      end
      if (!h) begin
        for (int s = 0; s < NSLOT; s++) begin
          if (set_mode && s % NSET != set_no) continue;
          if (!tag_valid[s]) begin
            found_free = 1'b1;
            sl = s;
            break;
          end
          if (!have_min || use_cnt[s] < use_cnt[min_slot]) begin
            have_min = 1'b1;
            min_slot = s;
          end
        end
        if (!found_free) begin
          sl = min_slot;
          ev = 1'b1;
        end
      end
    end
    if (h) begin
      if (hits_so_far != '1) hits_so_far++;
    end else begin
      tag_valid[sl] = 1'b1;
      tag_line[sl] = line;
    end
    if (use_cnt[sl] != '1) use_cnt[sl]++;
    r.hit = h;
    r.slot = SLOT_OUT_BITS'(sl);
    r.evicted = ev;
    r.total = hits_so_far;
  endtask

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (mismatches < 10)
      $display("mismatch on %s: expected %0h, got %0h", field, want, got);
    mismatches++;
  endtask

  // waits until the unit has nothing in flight, then writes the mode
  task automatic set_mode(input logic [1:0] m);
    in_valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode = m;
  endtask

  task automatic send_lookup(input logic [31:0] a, input bit typed,
                             input lookup_t want);
    lookup_t r;
    int gap;
    gap = ((accepted / 50) % 3 == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_addr <= a;
    do @(posedge clk); while (!in_ready);
    predict_lookup(a, r);
    expected_lookups.push_back(typed ? want : r);
    accepted++;
  endtask

  function automatic lookup_t res(input logic h, input int sl, input logic ev,
                                  input logic [31:0] tot);
    lookup_t r;
    r.hit = h;
    r.slot = SLOT_OUT_BITS'(sl);
    r.evicted = ev;
    r.total = tot;
    return r;
  endfunction

  initial begin
    logic [1:0] phase_modes [NUM_PHASES];
    logic [31:0] pool [$];
    logic [31:0] a;
    int pool_size;
    lookup_t none;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= MODE_FULL;
    in_valid <= 1'b0;
    in_addr <= '0;
    none = '0;
    for (int s = 0; s < NSLOT; s++) begin
      tag_valid[s] = 1'b0;
      tag_line[s] = '0;
      use_cnt[s] = '0;
    end
    hits_so_far = '0;
    cur_mode = MODE_FULL;

    // fully associative from reset, offset bits ignored
    rows[0] = '{MODE_FULL, 32'h0000_0000, 1'b1, res(1'b0, 0, 1'b0, 0)};
    rows[1] = '{MODE_FULL, 32'hFFFF_FFFF, 1'b1, res(1'b0, 1, 1'b0, 0)};
    rows[2] = '{MODE_FULL, 32'h0000_001F, 1'b1, res(1'b1, 0, 1'b0, 1)};
    // tags kept across a mode change
    rows[3] = '{MODE_DIRECT, 32'h0000_0000, 1'b1, res(1'b1, 0, 1'b0, 2)};
    rows[4] = '{MODE_DIRECT, 32'hFFFF_FFFF, 1'b1, res(1'b0, 127, 1'b0, 2)};
    rows[5] = '{MODE_DIRECT, 32'h0000_1000, 1'b1, res(1'b0, 0, 1'b1, 2)};
    rows[6] = '{MODE_SET, 32'hFFFF_FFFF, 1'b1, res(1'b1, 127, 1'b0, 3)};
    rows[7] = '{MODE_SET, 32'h8000_0000, 1'b0, none};
    rows[8] = '{MODE_SET, 32'h7FFF_FFE0, 1'b0, none};
    // spare mode fills set 0 past its ways to force an eviction
    for (int k = 1; k <= 10; k++)
      rows[8 + k] = '{MODE_SPARE, k << 9, 1'b0, none};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (rows[i].mode != cur_mode) set_mode(rows[i].mode);
      send_lookup(rows[i].addr, rows[i].typed, rows[i].want);
    end

    phase_modes = '{MODE_SET, MODE_FULL, MODE_DIRECT, MODE_SPARE, MODE_FULL, MODE_SET};
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_mode(phase_modes[p]);
      pool_size = (p == 4) ? 180 : 24;
      pool.delete();
      for (int i = 0; i < pool_size; i++) pool.push_back($urandom());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 9) < 7)
          a = pool[$urandom_range(0, pool_size - 1)] ^ $urandom_range(0, 31);
        else
          a = $urandom();
        send_lookup(a, 1'b0, none);
      end
    end
    in_valid <= 1'b0;

    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("cache_tag_lookup_count_replace_unit verification clean");
    else
      $display("cache_tag_lookup_count_replace_unit verification failed");
    $finish;
  end

  // long receiver stall so the unit backs up into its input
  initial begin
    while (accepted < 300) @(posedge clk);
    hold_results = 1'b1;
    repeat (3000) @(posedge clk);
    hold_results = 1'b0;
  end

  initial begin
    lookup_t want;
    int w;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      w = ((returned / 40) % 3 == 1) ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      while (hold_results) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      returned++;
      if (expected_lookups.size() == 0) begin
        report_field("unexpected item", 32'h0, 32'h1);
      end else begin
        want = expected_lookups.pop_front();
        if (out_hit !== want.hit) report_field("hit", want.hit, out_hit);
        if (out_slot !== want.slot) report_field("slot", want.slot, out_slot);
        if (out_evicted !== want.evicted)
          report_field("evicted", want.evicted, out_evicted);
        if (out_hit_total !== want.total)
          report_field("hit_total", want.total, out_hit_total);
      end
    end
  end

endmodule
